>>> hw/rtl/kv_cache_checked_address_gen_defines.svh
// Assertion macros shared by the key/value cache address generator.
`ifndef KV_CACHE_CHECKED_ADDRESS_GEN_DEFINES_SVH
`define KV_CACHE_CHECKED_ADDRESS_GEN_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define KVCAG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define KVCAG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/kvcag_pkg.sv
// Package with codes, widths and pipeline types of the key/value cache address generator.
`timescale 1ns / 1ps
`default_nettype none
package kvcag_pkg;

  // Request kinds.
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_COMMIT = 2'd2;

  // Result status codes.
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_NOT_LIVE  = 4'd1;
  localparam logic [3:0] ST_LAYOUT    = 4'd2;
  localparam logic [3:0] ST_LAYER     = 4'd3;
  localparam logic [3:0] ST_HEAD      = 4'd4;
  localparam logic [3:0] ST_POSITION  = 4'd5;
  localparam logic [3:0] ST_DIM       = 4'd6;
  localparam logic [3:0] ST_OVERFLOW  = 4'd7;
  localparam logic [3:0] ST_BACKWARDS = 4'd8;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_LAYER_COUNT  = 3'd0;
  localparam logic [2:0] REG_HEAD_COUNT   = 3'd1;
  localparam logic [2:0] REG_TOKEN_LIMIT  = 3'd2;
  localparam logic [2:0] REG_DIM_COUNT    = 3'd3;
  localparam logic [2:0] REG_LAYER_STEP   = 3'd4;
  localparam logic [2:0] REG_HEAD_STEP    = 3'd5;
  localparam logic [2:0] REG_TOKEN_STEP   = 3'd6;
  localparam logic [2:0] REG_SESSION_CAP  = 3'd7;

  localparam int STEP_W  = 48;
  localparam int POS_W   = 24;
  localparam int PROD_W  = 56;  // 8-bit index times 48-bit step
  localparam int HALF_W  = 48;  // 24-bit position times 24-bit half step
  localparam int DIMT_W  = 16;  // 12-bit dim index times element size up to 8
  localparam int SUMA_W  = 57;
  localparam int SUMB_W  = 73;
  localparam int SUM_W   = 74;

  typedef struct packed {
    logic [1:0]  action;
    logic        view_live;
    logic [7:0]  layer_index;
    logic [7:0]  head_index;
    logic [23:0] token_pos;
    logic [11:0] dim_index;
    logic [23:0] commit_pos;
  } req_t;

  typedef struct packed {
    logic [3:0]        status;
    logic              access_ok;
    logic [POS_W-1:0]  committed;
    logic [PROD_W-1:0] p_layer;
    logic [PROD_W-1:0] p_head;
    logic [HALF_W-1:0] p_lo;
    logic [HALF_W-1:0] p_hi;
    logic [DIMT_W-1:0] dim_term;
  } prod_t;

  typedef struct packed {
    logic [3:0]        status;
    logic              access_ok;
    logic [POS_W-1:0]  committed;
    logic [SUMA_W-1:0] sum_a;
    logic [SUMB_W-1:0] sum_b;
  } psum_t;

endpackage
`default_nettype wire

>>> hw/rtl/kv_cache_checked_address_gen.sv
// Checked byte offset generator for a key/value cache with a committed token position.
`timescale 1ns / 1ps
`default_nettype none
`include "kv_cache_checked_address_gen_defines.svh"
// Usage:
// Each request on the in_ channel is a write access, a read access or a commit.
// An access is checked for a live view, a valid layout, the layer and head ranges,
// the token position and the dim index, in that order, and then yields the byte
// offset of the element; an offset beyond OFFSET_BITS reports overflow.
// A commit moves the committed token position forward only.
// Every request gives exactly one result on the out_ channel, in request order.
// One request can be accepted every cycle unless the pipeline is full and out_ready
// is low. Each request passes in order through the four-stage pipeline: an
// input register, a stage of products (the 24 by 48 bit token term is split into
// two 24 by 24 bit products), a stage of partial sums and the result register.
// When the receiver holds out_ready low, empty stages still fill, and in_ready
// drops only once all four stages hold a request.
// The user must write the layout registers through the APB-style port only while
// the block is idle; the block does not enforce this. A synchronous reset on rst_n
// empties the pipeline and zeroes the committed position and every layout register.
module kv_cache_checked_address_gen #(
  parameter int ELEMENT_BYTES = 2,
  parameter int OFFSET_BITS   = 48
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic        in_view_live,
  input  wire logic [7:0]  in_layer_index,
  input  wire logic [7:0]  in_head_index,
  input  wire logic [23:0] in_token_pos,
  input  wire logic [11:0] in_dim_index,
  input  wire logic [23:0] in_commit_pos,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_status,
  output logic [47:0]      out_byte_offset,
  output logic [23:0]      out_commit_level,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import kvcag_pkg::*;

  // Layout registers.
  logic [7:0]        layer_count_r;
  logic [7:0]        head_count_r;
  logic [23:0]       token_limit_r;
  logic [12:0]       dim_count_r;
  logic [STEP_W-1:0] layer_step_r;
  logic [STEP_W-1:0] head_step_r;
  logic [STEP_W-1:0] token_step_r;
  logic [23:0]       session_cap_r;

  logic [2:0] reg_idx;
  logic       cfg_we;

  // Committed token position.
  logic [POS_W-1:0] committed_position_r;
  logic [POS_W-1:0] committed_position_nxt;

  // Pipeline stages.
  logic  s0_v_r, s1_v_r, s2_v_r, s3_v_r;
  req_t  s0_r;
  prod_t s1_r, s1_nxt;
  psum_t s2_r, s2_nxt;
  logic [3:0]  s3_status_r, s3_status_nxt;
  logic [47:0] s3_offset_r, s3_offset_nxt;
  logic [23:0] s3_committed_r;

  logic en0, en1, en2, en3;

  // Stage 1 check signals.
  logic        layout_ok;
  logic [24:0] pos_p1;
  logic        commit_take;

  // Stage 3 signals.
  logic [SUM_W-1:0] total;
  logic             ovf;

  // Terms watched by the assertions.
  logic commit_fwd;
  logic commit_move;
  logic offset_set;
  logic pipe_full;

  // A stage takes new contents when it is empty or its contents move on.
  assign en3      = !s3_v_r || out_ready;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign en0      = !s0_v_r || en1;
  assign in_ready = en0;

  // ---------------------------------------------------------------------------
  // Configuration port: one 64-bit slot per register, pready always high.
  // ---------------------------------------------------------------------------
  assign reg_idx = paddr[5:3];
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_count_r <= '0;
      head_count_r  <= '0;
      token_limit_r <= '0;
      dim_count_r   <= '0;
      layer_step_r  <= '0;
      head_step_r   <= '0;
      token_step_r  <= '0;
      session_cap_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_LAYER_COUNT: layer_count_r <= pwdata[7:0];
        REG_HEAD_COUNT:  head_count_r  <= pwdata[7:0];
        REG_TOKEN_LIMIT: token_limit_r <= pwdata[23:0];
        REG_DIM_COUNT:   dim_count_r   <= pwdata[12:0];
        REG_LAYER_STEP:  layer_step_r  <= pwdata[STEP_W-1:0];
        REG_HEAD_STEP:   head_step_r   <= pwdata[STEP_W-1:0];
        REG_TOKEN_STEP:  token_step_r  <= pwdata[STEP_W-1:0];
        REG_SESSION_CAP: session_cap_r <= pwdata[23:0];
        default:         layer_count_r <= layer_count_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LAYER_COUNT: prdata = 64'(layer_count_r);
      REG_HEAD_COUNT:  prdata = 64'(head_count_r);
      REG_TOKEN_LIMIT: prdata = 64'(token_limit_r);
      REG_DIM_COUNT:   prdata = 64'(dim_count_r);
      REG_LAYER_STEP:  prdata = 64'(layer_step_r);
      REG_HEAD_STEP:   prdata = 64'(head_step_r);
      REG_TOKEN_STEP:  prdata = 64'(token_step_r);
      REG_SESSION_CAP: prdata = 64'(session_cap_r);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage 1: all checks, the commit update and the partial products.
  // Every earlier request has already left this stage, so the committed
  // position seen here is always current.
  // ---------------------------------------------------------------------------
  assign layout_ok = (layer_count_r != '0) && (head_count_r != '0) &&
                     (token_limit_r != '0) && (dim_count_r != '0);
  assign pos_p1    = {1'b0, s0_r.token_pos} + 25'd1;

  always_comb begin
    s1_nxt.status    = ST_OK;
    s1_nxt.access_ok = 1'b0;
    commit_take      = 1'b0;
    priority if (s0_r.action != ACT_WRITE && s0_r.action != ACT_READ &&
                 s0_r.action != ACT_COMMIT) begin
      s1_nxt.status = ST_OK;
    end else if (!s0_r.view_live) begin
      s1_nxt.status = ST_NOT_LIVE;
    end else if (!layout_ok) begin
      s1_nxt.status = ST_LAYOUT;
    end else if (s0_r.action == ACT_COMMIT) begin
      if (s0_r.commit_pos < committed_position_r) begin
        s1_nxt.status = ST_BACKWARDS;
      end else if (s0_r.commit_pos > session_cap_r) begin
        s1_nxt.status = ST_POSITION;
      end else begin
        commit_take = 1'b1;
      end
    end else if (s0_r.layer_index >= layer_count_r) begin
      s1_nxt.status = ST_LAYER;
    end else if (s0_r.head_index >= head_count_r) begin
      s1_nxt.status = ST_HEAD;
    end else if (s0_r.action == ACT_WRITE &&
                 (pos_p1 > {1'b0, session_cap_r} || pos_p1 > {1'b0, token_limit_r})) begin
      s1_nxt.status = ST_POSITION;
    end else if (s0_r.action == ACT_READ &&
                 (pos_p1 > {1'b0, committed_position_r} ||
                  s0_r.token_pos >= token_limit_r)) begin
      s1_nxt.status = ST_POSITION;
    end else if ({1'b0, s0_r.dim_index} >= dim_count_r) begin
      s1_nxt.status = ST_DIM;
    end else begin
      s1_nxt.access_ok = 1'b1;
    end

    committed_position_nxt = commit_take ? s0_r.commit_pos : committed_position_r;
    s1_nxt.committed       = committed_position_nxt;

    s1_nxt.p_layer  = PROD_W'(s0_r.layer_index) * PROD_W'(layer_step_r);
    s1_nxt.p_head   = PROD_W'(s0_r.head_index) * PROD_W'(head_step_r);
    s1_nxt.p_lo     = HALF_W'(s0_r.token_pos) * HALF_W'(token_step_r[23:0]);
    s1_nxt.p_hi     = HALF_W'(s0_r.token_pos) * HALF_W'(token_step_r[47:24]);
    s1_nxt.dim_term = DIMT_W'(s0_r.dim_index) * DIMT_W'(ELEMENT_BYTES);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: two partial sums.
  // ---------------------------------------------------------------------------
  always_comb begin
    s2_nxt.status    = s1_r.status;
    s2_nxt.access_ok = s1_r.access_ok;
    s2_nxt.committed = s1_r.committed;
    s2_nxt.sum_a     = SUMA_W'(s1_r.p_layer) + SUMA_W'(s1_r.p_head);
    s2_nxt.sum_b     = SUMB_W'(s1_r.p_lo) + (SUMB_W'(s1_r.p_hi) << 24) +
                       SUMB_W'(s1_r.dim_term);
  end

  // ---------------------------------------------------------------------------
  // Stage 3: exact sum and overflow flag.
  // ---------------------------------------------------------------------------
  always_comb begin
    total         = SUM_W'(s2_r.sum_a) + SUM_W'(s2_r.sum_b);
    ovf           = s2_r.access_ok && ((total >> OFFSET_BITS) != '0);
    s3_status_nxt = ovf ? ST_OVERFLOW : s2_r.status;
    s3_offset_nxt = (s2_r.access_ok && !ovf) ? total[47:0] : '0;
  end

  // ---------------------------------------------------------------------------
  // Pipeline registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r               <= 1'b0;
      s1_v_r               <= 1'b0;
      s2_v_r               <= 1'b0;
      s3_v_r               <= 1'b0;
      committed_position_r <= '0;
    end else begin
      if (en0) s0_v_r <= in_valid;
      if (en1) s1_v_r <= s0_v_r;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
      if (en1 && s0_v_r) committed_position_r <= committed_position_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      s0_r.action      <= in_action;
      s0_r.view_live   <= in_view_live;
      s0_r.layer_index <= in_layer_index;
      s0_r.head_index  <= in_head_index;
      s0_r.token_pos   <= in_token_pos;
      s0_r.dim_index   <= in_dim_index;
      s0_r.commit_pos  <= in_commit_pos;
    end
    if (en1) s1_r <= s1_nxt;
    if (en2) s2_r <= s2_nxt;
    if (en3) begin
      s3_status_r    <= s3_status_nxt;
      s3_offset_r    <= s3_offset_nxt;
      s3_committed_r <= s2_r.committed;
    end
  end

  assign out_valid        = s3_v_r;
  assign out_status       = s3_status_r;
  assign out_byte_offset  = s3_offset_r;
  assign out_commit_level = s3_committed_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  assign commit_fwd  = committed_position_nxt >= committed_position_r;
  assign commit_move = s0_v_r && en1 && (s0_r.action == ACT_COMMIT);
  assign offset_set  = out_valid && (out_byte_offset != '0);
  assign pipe_full   = out_valid && !out_ready && s0_v_r && s1_v_r && s2_v_r;

  `KVCAG_ASSERT_NOW(a_commit_forward, 1'b1, commit_fwd, "committed position moved backwards")
  `KVCAG_ASSERT_NEXT(a_commit_src, !commit_move, $stable(committed_position_r), "stray commit")
  `KVCAG_ASSERT_NOW(a_offset_only_ok, offset_set, out_status == ST_OK, "offset on failed request")
  `KVCAG_ASSERT_NOW(a_full_when_blocked, !in_ready, pipe_full, "in_ready low with a free stage")

endmodule
`default_nettype wire

>>> tb/kv_cache_addr_checker.sv
// Checker that predicts and compares every result of the key/value cache address generator.
`timescale 1ns / 1ps
module kv_cache_addr_checker #(
  parameter int ELEMENT_BYTES = 2,
  parameter int OFFSET_BITS   = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic        in_view_live,
  input  logic [7:0]  in_layer_index,
  input  logic [7:0]  in_head_index,
  input  logic [23:0] in_token_pos,
  input  logic [11:0] in_dim_index,
  input  logic [23:0] in_commit_pos,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  out_status,
  input  logic [47:0] out_byte_offset,
  input  logic [23:0] out_commit_level,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output int          pending_results,
  output int          mismatches
);
  import kvcag_pkg::*;

  typedef struct {
    logic [3:0]  status;
    logic [47:0] byte_offset;
    logic [23:0] commit_level;
  } access_result_t;

  // Shadow copy of the layout registers and of the committed position.
  logic [7:0]  layers;
  logic [7:0]  heads;
  logic [23:0] tok_limit;
  logic [12:0] dims;
  logic [47:0] layer_step;
  logic [47:0] head_step;
  logic [47:0] token_step;
  logic [23:0] capacity;
  logic [23:0] committed_pos;

  access_result_t result_q[$];

  initial mismatches = 0;
  initial pending_results = 0;

  // Works out the result of one request and advances the committed position.
  function automatic access_result_t predict_access(input req_t rq);
    access_result_t res;
    logic layout_ok;
    logic [24:0] pos_end;
    logic [79:0] total;
    res.status = ST_OK;
    res.byte_offset = '0;
    layout_ok = (layers != 0) && (heads != 0) && (tok_limit != 0) && (dims != 0);
    pos_end = {1'b0, rq.token_pos} + 25'd1;
    if (rq.action != ACT_WRITE && rq.action != ACT_READ && rq.action != ACT_COMMIT) begin
      res.status = ST_OK;
    end else if (!rq.view_live) begin
      res.status = ST_NOT_LIVE;
    end else if (!layout_ok) begin
      res.status = ST_LAYOUT;
    end else if (rq.action == ACT_COMMIT) begin
      if (rq.commit_pos < committed_pos) res.status = ST_BACKWARDS;
      else if (rq.commit_pos > capacity) res.status = ST_POSITION;
      else committed_pos = rq.commit_pos;
    end else if (rq.layer_index >= layers) begin
      res.status = ST_LAYER;
    end else if (rq.head_index >= heads) begin
      res.status = ST_HEAD;
    end else if (rq.action == ACT_WRITE &&
                 (pos_end > {1'b0, capacity} || pos_end > {1'b0, tok_limit})) begin
      res.status = ST_POSITION;
    end else if (rq.action == ACT_READ &&
                 (pos_end > {1'b0, committed_pos} || rq.token_pos >= tok_limit)) begin
      res.status = ST_POSITION;
    end else if ({1'b0, rq.dim_index} >= dims) begin
      res.status = ST_DIM;
    end else begin
      // The exact sum needs at most 74 bits, so 80 bits never wrap.
      total = 80'(rq.layer_index) * 80'(layer_step) + 80'(rq.head_index) * 80'(head_step)
            + 80'(rq.token_pos) * 80'(token_step) + 80'(rq.dim_index) * 80'(ELEMENT_BYTES);
      if ((total >> OFFSET_BITS) != 0) res.status = ST_OVERFLOW;
      else res.byte_offset = total[47:0];
    end
    res.commit_level = committed_pos;
    return res;
  endfunction

  always @(posedge clk) begin
    access_result_t want;
    req_t rq;
    if (!rst_n) begin
      layers = '0;
      heads = '0;
      tok_limit = '0;
      dims = '0;
      layer_step = '0;
      head_step = '0;
      token_step = '0;
      capacity = '0;
      committed_pos = '0;
      result_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_LAYER_COUNT: layers = pwdata[7:0];
          REG_HEAD_COUNT:  heads = pwdata[7:0];
          REG_TOKEN_LIMIT: tok_limit = pwdata[23:0];
          REG_DIM_COUNT:   dims = pwdata[12:0];
          REG_LAYER_STEP:  layer_step = pwdata[47:0];
          REG_HEAD_STEP:   head_step = pwdata[47:0];
          REG_TOKEN_STEP:  token_step = pwdata[47:0];
          REG_SESSION_CAP: capacity = pwdata[23:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result with no request outstanding: status %0d", out_status);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            mismatches++;
          end
          if (out_byte_offset !== want.byte_offset) begin
            $error("byte_offset: expected 0x%0h, actual 0x%0h",
                   want.byte_offset, out_byte_offset);
            mismatches++;
          end
          if (out_commit_level !== want.commit_level) begin
            $error("commit_level: expected %0d, actual %0d",
                   want.commit_level, out_commit_level);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        rq.action = in_action;
        rq.view_live = in_view_live;
        rq.layer_index = in_layer_index;
        rq.head_index = in_head_index;
        rq.token_pos = in_token_pos;
        rq.dim_index = in_dim_index;
        rq.commit_pos = in_commit_pos;
        result_q.push_back(predict_access(rq));
      end
    end
    pending_results <= result_q.size();
  end

endmodule

>>> tb/testbench.sv
// Top of the testbench: clock, reset, stimulus, receiver stalls and the final verdict.
`timescale 1ns / 1ps
module testbench;
  import kvcag_pkg::*;

  localparam int CLK_HALF_NS   = 4;
  localparam int RESET_CYCLES  = 3;
  localparam int RANDOM_PHASES = 12;
  localparam int PER_PHASE     = 77;
  localparam int PIPE_LATENCY  = 4;
  localparam int CYCLE_LIMIT   = 400000;

  // The package names the three defined actions; the fourth code does nothing.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_t;

  // Stimulus-side copy of the layout, used only to shape well-formed requests.
  typedef struct {
    logic [7:0]  layers;
    logic [7:0]  heads;
    logic [23:0] tok_limit;
    logic [12:0] dims;
    logic [47:0] layer_step;
    logic [47:0] head_step;
    logic [47:0] token_step;
    logic [23:0] capacity;
  } layout_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = ACT_WRITE;
  logic        in_view_live = 1'b0;
  logic [7:0]  in_layer_index = '0;
  logic [7:0]  in_head_index = '0;
  logic [23:0] in_token_pos = '0;
  logic [11:0] in_dim_index = '0;
  logic [23:0] in_commit_pos = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_status;
  logic [47:0] out_byte_offset;
  logic [23:0] out_commit_level;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  int results_outstanding;
  int mismatch_total;

  layout_t     cur;
  logic [23:0] commit_hint;
  int          sent = 0;
  int          directed_sent = 0;
  int          settings = 0;
  int          burst_left = 0;
  int          cycle_count = 0;
  ready_mode_t ready_mode = READY_ALWAYS;
  int          ready_run = 0;

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  kv_cache_checked_address_gen i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_view_live     (in_view_live),
    .in_layer_index   (in_layer_index),
    .in_head_index    (in_head_index),
    .in_token_pos     (in_token_pos),
    .in_dim_index     (in_dim_index),
    .in_commit_pos    (in_commit_pos),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_byte_offset  (out_byte_offset),
    .out_commit_level (out_commit_level),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // The checker sits beside the block and sees exactly what the block sees.
  kv_cache_addr_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_view_live     (in_view_live),
    .in_layer_index   (in_layer_index),
    .in_head_index    (in_head_index),
    .in_token_pos     (in_token_pos),
    .in_dim_index     (in_dim_index),
    .in_commit_pos    (in_commit_pos),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_byte_offset  (out_byte_offset),
    .out_commit_level (out_commit_level),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pending_results  (results_outstanding),
    .mismatches       (mismatch_total)
  );

  // The receiver switches between runs of full throughput, coin-flip stalls
  // and long stretches where it takes only one result in four.
  always @(posedge clk) begin
    if (ready_run == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 2));
      ready_run = $urandom_range(4, 48);
    end
    ready_run = ready_run - 1;
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_COIN:   out_ready <= 1'($urandom);
      default:      out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Hard stop in case the block hangs or drops a result.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, results_outstanding);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic req_t mk_req(input logic [1:0] action, input logic live,
                                  input logic [7:0] layer, input logic [7:0] head,
                                  input logic [23:0] pos, input logic [11:0] dim,
                                  input logic [23:0] cpos);
    req_t r;
    r.action = action;
    r.view_live = live;
    r.layer_index = layer;
    r.head_index = head;
    r.token_pos = pos;
    r.dim_index = dim;
    r.commit_pos = cpos;
    return r;
  endfunction

  // Mostly a legal index below the span; now and then exactly the span, which is
  // the first value that must be rejected.
  function automatic logic [23:0] pick_index(input int span);
    if (span == 0 || $urandom_range(0, 15) == 0) return 24'(span);
    return 24'($urandom_range(0, span - 1));
  endfunction

  function automatic logic [47:0] random_step();
    int m;
    m = $urandom_range(0, 9);
    if (m < 6) return 48'($urandom_range(0, 65536));
    if (m < 8) return {16'($urandom), 32'($urandom)};
    if (m == 8) return '1;
    return '0;
  endfunction

  // Capacities grow from phase to phase, since the committed position never
  // goes back and small sessions late in the run would block every commit.
  function automatic layout_t random_layout(input int phase);
    layout_t c;
    int cap_hi;
    cap_hi = 32 << (phase * 2);
    if (phase == RANDOM_PHASES - 1 || cap_hi > 24'hFFFFFF) cap_hi = 24'hFFFFFF;
    c.layers = 8'($urandom_range(1, 255));
    c.heads = 8'($urandom_range(1, 255));
    c.tok_limit = 24'($urandom_range(1, cap_hi));
    c.dims = 13'($urandom_range(1, 4096));
    c.layer_step = random_step();
    c.head_step = random_step();
    c.token_step = random_step();
    c.capacity = 24'($urandom_range(0, cap_hi));
    // Roughly one setting in five has an invalid layout.
    case ($urandom_range(0, 19))
      0: c.layers = '0;
      1: c.heads = '0;
      2: c.tok_limit = '0;
      3: c.dims = '0;
      default: ;
    endcase
    return c;
  endfunction

  // Most requests are well formed so they get past the early checks; a tenth
  // are pure noise over every field, including the unused action code.
  function automatic req_t random_request();
    req_t r;
    int pick;
    int span;
    pick = $urandom_range(0, 99);
    r.action = 2'($urandom);
    r.view_live = 1'($urandom);
    r.layer_index = 8'($urandom);
    r.head_index = 8'($urandom);
    r.token_pos = 24'($urandom);
    r.dim_index = 12'($urandom);
    r.commit_pos = 24'($urandom);
    if (pick < 10) return r;
    r.view_live = ($urandom_range(0, 19) != 0);
    if (pick < 25) begin
      r.action = ACT_COMMIT;
      r.commit_pos = commit_hint + 24'($urandom_range(0, 3));
      if (commit_hint != 0 && $urandom_range(0, 9) == 0) r.commit_pos = commit_hint - 24'd1;
      return r;
    end
    r.layer_index = 8'(pick_index(cur.layers));
    r.head_index = 8'(pick_index(cur.heads));
    r.dim_index = 12'(pick_index(cur.dims));
    if (pick < 65) begin
      r.action = ACT_WRITE;
      span = (cur.capacity < cur.tok_limit) ? cur.capacity : cur.tok_limit;
    end else begin
      r.action = ACT_READ;
      span = (commit_hint < cur.tok_limit) ? commit_hint : cur.tok_limit;
    end
    r.token_pos = pick_index(span);
    return r;
  endfunction

  // Presents one request and returns at the edge where it is accepted. Bursts of
  // random length are separated by random gaps; about a quarter of the bursts
  // follow the previous one back to back.
  task automatic send_req(input req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_action <= r.action;
    in_view_live <= r.view_live;
    in_layer_index <= r.layer_index;
    in_head_index <= r.head_index;
    in_token_pos <= r.token_pos;
    in_dim_index <= r.dim_index;
    in_commit_pos <= r.commit_pos;
    do @(posedge clk); while (!in_ready);
    sent++;
    // Follow the committed position so reads can aim below it.
    if (r.action == ACT_COMMIT && r.view_live && cur.layers != 0 && cur.heads != 0 &&
        cur.tok_limit != 0 && cur.dims != 0 && r.commit_pos >= commit_hint &&
        r.commit_pos <= cur.capacity) begin
      commit_hint = r.commit_pos;
    end
  endtask

  // Stops sending and waits until every result has been taken. The count from
  // the checker is registered, so the task lets an edge pass before trusting it.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
  endtask

  // Writes all eight layout registers back to back through the APB-style port:
  // a setup phase, then an access phase that completes when pready is high.
  task automatic program_layout(input layout_t c);
    logic [63:0] vals [8];
    int k;
    vals[REG_LAYER_COUNT] = 64'(c.layers);
    vals[REG_HEAD_COUNT] = 64'(c.heads);
    vals[REG_TOKEN_LIMIT] = 64'(c.tok_limit);
    vals[REG_DIM_COUNT] = 64'(c.dims);
    vals[REG_LAYER_STEP] = 64'(c.layer_step);
    vals[REG_HEAD_STEP] = 64'(c.head_step);
    vals[REG_TOKEN_STEP] = 64'(c.token_step);
    vals[REG_SESSION_CAP] = 64'(c.capacity);
    for (k = 0; k < 8; k++) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {3'(k), 3'b000};
      pwdata <= vals[k];
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur = c;
    settings++;
  endtask

  initial begin
    layout_t c;
    int p;
    int i;
    cur = '{default: '0};
    commit_hint = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Straight out of reset every layout register is zero, so a live access
    // reports an invalid layout; a dead commit and the unused code follow it.
    send_req(mk_req(ACT_WRITE, 1'b1, 8'd0, 8'd0, 24'd0, 12'd0, 24'd0));
    send_req(mk_req(ACT_COMMIT, 1'b0, 8'd0, 8'd0, 24'd0, 12'd0, 24'hFFFFFF));
    send_req(mk_req(ACT_UNUSED, 1'b1, 8'hFF, 8'hFF, 24'hFFFFFF, 12'hFFF, 24'hFFFFFF));
    wait_for_results();

    // A small layout where the session is shorter than the token capacity.
    c = '{layers: 8'd4, heads: 8'd2, tok_limit: 24'd100, dims: 13'd64,
          layer_step: 48'h10000, head_step: 48'h1000, token_step: 48'h80,
          capacity: 24'd50};
    program_layout(c);
    send_req(mk_req(ACT_COMMIT, 1'b1, 8'd0, 8'd0, 24'd0, 12'd0, 24'd10));
    // Commits that go backwards or past the session are refused.
    send_req(mk_req(ACT_COMMIT, 1'b1, 8'd0, 8'd0, 24'd0, 12'd0, 24'd5));
    send_req(mk_req(ACT_COMMIT, 1'b1, 8'd0, 8'd0, 24'd0, 12'd0, 24'd51));
    send_req(mk_req(ACT_WRITE, 1'b1, 8'd4, 8'd0, 24'd0, 12'd0, 24'd0));
    send_req(mk_req(ACT_WRITE, 1'b1, 8'd0, 8'd2, 24'd0, 12'd0, 24'd0));
    // The last writable position of the session, then one past it.
    send_req(mk_req(ACT_WRITE, 1'b1, 8'd1, 8'd1, 24'd49, 12'd0, 24'd0));
    send_req(mk_req(ACT_WRITE, 1'b1, 8'd1, 8'd1, 24'd50, 12'd0, 24'd0));
    // Reads stop just below the committed position.
    send_req(mk_req(ACT_READ, 1'b1, 8'd0, 8'd0, 24'd9, 12'd5, 24'd0));
    send_req(mk_req(ACT_READ, 1'b1, 8'd0, 8'd0, 24'd10, 12'd5, 24'd0));
    send_req(mk_req(ACT_WRITE, 1'b1, 8'd0, 8'd0, 24'd0, 12'd64, 24'd0));
    send_req(mk_req(ACT_WRITE, 1'b1, 8'd3, 8'd1, 24'd49, 12'd63, 24'd0));
    send_req(mk_req(ACT_UNUSED, 1'b0, 8'd0, 8'd0, 24'd0, 12'd0, 24'd0));
    send_req(mk_req(ACT_READ, 1'b0, 8'd0, 8'd0, 24'd0, 12'd0, 24'd0));
    send_req(mk_req(ACT_WRITE, 1'b1, 8'hFF, 8'hFF, 24'd0, 12'd0, 24'd0));
    wait_for_results();

    // Every register at its largest value, but the dim count at 4096.
    c = '{layers: 8'hFF, heads: 8'hFF, tok_limit: 24'hFFFFFF, dims: 13'd4096,
          layer_step: '1, head_step: '1, token_step: '1, capacity: 24'hFFFFFF};
    program_layout(c);
    send_req(mk_req(ACT_COMMIT, 1'b0, 8'd0, 8'd0, 24'd0, 12'd0, 24'hFFFFFF));
    send_req(mk_req(ACT_WRITE, 1'b1, 8'd0, 8'd0, 24'hFFFFFF, 12'd0, 24'd0));
    send_req(mk_req(ACT_WRITE, 1'b1, 8'hFE, 8'hFE, 24'hFFFFFE, 12'hFFF, 24'd0));
    send_req(mk_req(ACT_WRITE, 1'b1, 8'd0, 8'd0, 24'd0, 12'hFFF, 24'd0));
    wait_for_results();

    // Offsets right at the top of the 48-bit range, a token capacity below the
    // session size, and a committed position beyond the token capacity.
    c = '{layers: 8'd2, heads: 8'd2, tok_limit: 24'd4, dims: 13'd2,
          layer_step: 48'h8000_0000_0000, head_step: 48'h7FFF_FFFF_FFFE,
          token_step: 48'd0, capacity: 24'd8};
    program_layout(c);
    send_req(mk_req(ACT_WRITE, 1'b1, 8'd1, 8'd1, 24'd0, 12'd0, 24'd0));
    send_req(mk_req(ACT_WRITE, 1'b1, 8'd1, 8'd1, 24'd0, 12'd1, 24'd0));
    send_req(mk_req(ACT_WRITE, 1'b1, 8'd0, 8'd0, 24'd4, 12'd0, 24'd0));
    send_req(mk_req(ACT_READ, 1'b1, 8'd0, 8'd0, 24'd5, 12'd0, 24'd0));
    wait_for_results();
    directed_sent = sent;

    // Random phases, each under a fresh layout. Halfway through the run the
    // sender also holds off mid-phase until the pipeline has emptied.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      program_layout(random_layout(p));
      for (i = 0; i < PER_PHASE; i++) begin
        if (p == RANDOM_PHASES / 2 && i == PER_PHASE / 2) wait_for_results();
        send_req(random_request());
      end
      wait_for_results();
    end

    // Give a stray late result time to show up before the verdict.
    repeat (PIPE_LATENCY) @(posedge clk);
    $display("Run covered %0d requests (%0d directed) under %0d register settings.",
             sent, directed_sent, settings);
    $display("Checker counted %0d mismatches over %0d cycles.", mismatch_total, cycle_count);
    if (mismatch_total == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
